### sv/nv21_pkg.sv
// Shared constants, types and helpers for the NV21 block to RGBA converter.
// No dependencies; every other file imports this package.
package nv21_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int LUMA_W  = 8;
  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 11;
  localparam int DEST_W  = 12;
  localparam int RGBA_W  = 32;
  localparam int LANES   = 4;

  // 16.16 sums of the BT.601 terms stay within +-2^26
  localparam int SUM_W  = 27;
  localparam int COEF_W = 19;
  localparam int DIFF_W = 10;

  localparam logic signed [COEF_W-1:0] COEF_Y  = 19'sd76309;
  localparam logic signed [COEF_W-1:0] COEF_RV = 19'sd104597;
  localparam logic signed [COEF_W-1:0] COEF_GU = 19'sd25675;
  localparam logic signed [COEF_W-1:0] COEF_GV = 19'sd53279;
  localparam logic signed [COEF_W-1:0] COEF_BU = 19'sd132201;
  localparam logic signed [DIFF_W-1:0] LUMA_OFFSET   = 10'sd16;
  localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 10'sd128;
  localparam logic [7:0] ALPHA = 8'd255;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [SIZE_W-1:0] SIZE_MIN     = 13'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MIRROR       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest_row;
    logic [DEST_W-1:0] dest_col;
    logic              frame_done;
    logic              mirror;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rv;
    logic signed [SUM_W-1:0] gu;
    logic signed [SUM_W-1:0] gv;
    logic signed [SUM_W-1:0] bu;
  } chroma_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest_row;
    logic [DEST_W-1:0] dest_col;
    logic [RGBA_W-1:0] upper_left_rgba;
    logic [RGBA_W-1:0] upper_right_rgba;
    logic [RGBA_W-1:0] lower_left_rgba;
    logic [RGBA_W-1:0] lower_right_rgba;
    logic              frame_done;
  } result_t;

  // floor(s / 65536), saturated to 0..255
  function automatic logic [7:0] clip_channel(input logic signed [SUM_W-1:0] s);
    logic [7:0] c;
    if (s[SUM_W-1]) begin
      c = 8'd0;
    end else if (|s[SUM_W-2:24]) begin
      c = 8'd255;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

  // clamp to 2..maxv, then clear the low bit
  function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] v,
                                                       input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] c;
    c = v;
    if (c < SIZE_MIN) c = SIZE_MIN;
    if (c > maxv) c = maxv;
    return {c[SIZE_W-1:1], 1'b0};
  endfunction

endpackage

### sv/nv21_if.sv
// Valid/ready channel interfaces for block input and converted output.
// Depends on nv21_pkg for field widths.
interface nv21_in_if import nv21_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma_top_left;
  logic [LUMA_W-1:0] luma_top_right;
  logic [LUMA_W-1:0] luma_bottom_left;
  logic [LUMA_W-1:0] luma_bottom_right;
  logic [LUMA_W-1:0] chroma_v;
  logic [LUMA_W-1:0] chroma_u;

  modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
                  luma_bottom_right, chroma_v, chroma_u, input ready);
  modport sink   (input valid, luma_top_left, luma_top_right, luma_bottom_left,
                  luma_bottom_right, chroma_v, chroma_u, output ready);
endinterface

interface nv21_out_if import nv21_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_row;
  logic [DEST_W-1:0] dest_col;
  logic [RGBA_W-1:0] upper_left_rgba;
  logic [RGBA_W-1:0] upper_right_rgba;
  logic [RGBA_W-1:0] lower_left_rgba;
  logic [RGBA_W-1:0] lower_right_rgba;
  logic              frame_done;

  modport source (output valid, dest_row, dest_col, upper_left_rgba, upper_right_rgba,
                  lower_left_rgba, lower_right_rgba, frame_done, input ready);
  modport sink   (input valid, dest_row, dest_col, upper_left_rgba, upper_right_rgba,
                  lower_left_rgba, lower_right_rgba, frame_done, output ready);
endinterface

### sv/nv21_ctrl.sv
// Configuration registers and block row/column counters.
// Produces the destination position of the block being accepted. Uses nv21_pkg.
module nv21_ctrl import nv21_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 advance,
  output pos_t                 pos
);

  logic [SIZE_W-1:0]  frame_width_r, frame_height_r;
  logic               mirror_enable_r;
  logic [COUNT_W-1:0] block_column_r, block_column_nxt;
  logic [COUNT_W-1:0] block_row_r, block_row_nxt;

  logic [SIZE_W-1:0]  eff_w, eff_h;
  logic [COUNT_W-1:0] last_col, last_row, col, row;
  logic [SIZE_W-1:0]  mirror_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RESET;
      frame_height_r  <= HEIGHT_RESET;
      mirror_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r  <= cfg_data;
        CFG_MIRROR:       mirror_enable_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    eff_w    = effective_size(frame_width_r, SIZE_W'(MAX_WIDTH));
    eff_h    = effective_size(frame_height_r, SIZE_W'(MAX_HEIGHT));
    last_col = COUNT_W'(eff_w[SIZE_W-1:1] - 1'b1);
    last_row = COUNT_W'(eff_h[SIZE_W-1:1] - 1'b1);
    // a counter left beyond a shrunken frame sits on the last block
    col = (block_column_r > last_col) ? last_col : block_column_r;
    row = (block_row_r > last_row) ? last_row : block_row_r;
    mirror_col = eff_w - SIZE_W'(2) - SIZE_W'({col, 1'b0});

    pos.dest_row   = {row, 1'b0};
    pos.dest_col   = mirror_enable_r ? mirror_col[DEST_W-1:0] : {col, 1'b0};
    pos.frame_done = (col == last_col) && (row == last_row);
    pos.mirror     = mirror_enable_r;

    if (col >= last_col) begin
      block_column_nxt = '0;
      block_row_nxt    = (row >= last_row) ? '0 : row + 1'b1;
    end else begin
      block_column_nxt = col + 1'b1;
      block_row_nxt    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_column_r <= '0;
      block_row_r    <= '0;
    end else if (advance) begin
      block_column_r <= block_column_nxt;
      block_row_r    <= block_row_nxt;
    end
  end

endmodule

### sv/nv21_lane.sv
// One pixel lane: luma product, then the three channel sums with saturation.
// Two register stages; chroma products arrive aligned with the luma product. Uses nv21_pkg.
module nv21_lane import nv21_pkg::*; (
  input  logic              clk,
  input  logic [LUMA_W-1:0] luma,
  input  chroma_t           chroma,
  output logic [RGBA_W-1:0] rgba_r
);

  logic signed [DIFF_W-1:0] luma_diff;
  logic signed [SUM_W-1:0]  luma_term_r, luma_term_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [RGBA_W-1:0]        rgba_nxt;

  always_comb begin
    luma_diff     = $signed({2'b00, luma}) - LUMA_OFFSET;
    luma_term_nxt = SUM_W'(COEF_Y) * SUM_W'(luma_diff);
  end

  always_ff @(posedge clk) begin
    luma_term_r <= luma_term_nxt;
  end

  always_comb begin
    sum_r    = luma_term_r + chroma.rv;
    sum_g    = luma_term_r - chroma.gu - chroma.gv;
    sum_b    = luma_term_r + chroma.bu;
    rgba_nxt = {ALPHA, clip_channel(sum_b), clip_channel(sum_g), clip_channel(sum_r)};
  end

  always_ff @(posedge clk) begin
    rgba_r <= rgba_nxt;
  end

endmodule

### sv/nv21_merge.sv
// Merges the four lane pixels with the block position, swapping left and right
// when mirrored, into a small result queue toward the output channel. Uses nv21_pkg.
module nv21_merge import nv21_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_valid,
  input  pos_t                         pos,
  input  logic [LANES-1:0][RGBA_W-1:0] pixels,
  input  logic                         rd_ready,
  output logic                         rd_valid,
  output result_t                      rd_data,
  output logic [QCNT_W-1:0]            count
);

  result_t            queue_r [QUEUE_DEPTH];
  result_t            entry;
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               rd_fire;

  always_comb begin
    entry.dest_row   = pos.dest_row;
    entry.dest_col   = pos.dest_col;
    entry.frame_done = pos.frame_done;
    if (pos.mirror) begin
      entry.upper_left_rgba  = pixels[1];
      entry.upper_right_rgba = pixels[0];
      entry.lower_left_rgba  = pixels[3];
      entry.lower_right_rgba = pixels[2];
    end else begin
      entry.upper_left_rgba  = pixels[0];
      entry.upper_right_rgba = pixels[1];
      entry.lower_left_rgba  = pixels[2];
      entry.lower_right_rgba = pixels[3];
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = queue_r[rd_ptr_r];
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    if (wr_valid && !rd_fire) count_nxt = count_r + 1'b1;
    if (!wr_valid && rd_fire) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_valid) queue_r[wr_ptr_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_fire)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

### sv/nv21_block_to_rgba.sv
// NV21 2x2 block to RGBA converter, BT.601, four pixel lanes side by side.
// Throughput: one block per cycle while input ready stays high. A result passes the
// luma/chroma multiply stage, the sum and saturate stage and the 4-entry result
// queue before it is offered on the output. Input ready drops only when the queue
// and the two pipeline stages together hold 4 blocks. Reset (sync, active low)
// empties the pipeline and queue, zeroes the block counters and loads 640x480, no mirror.
module nv21_block_to_rgba import nv21_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nv21_in_if.sink              in_chan,
  nv21_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic                         in_fire;
  pos_t                         cur_pos;
  pos_t                         pos_s1_r, pos_s2_r;
  logic                         s1_valid_r, s2_valid_r;
  chroma_t                      chroma_r, chroma_nxt;
  logic signed [DIFF_W-1:0]     v_diff, u_diff;
  logic [LANES-1:0][LUMA_W-1:0] luma;
  logic [LANES-1:0][RGBA_W-1:0] pixels;
  logic [QCNT_W-1:0]            queue_count;
  logic [QCNT_W:0]              occupancy;
  result_t                      result;

  // credit check: everything in flight must fit the queue
  assign occupancy    = {1'b0, queue_count} + (QCNT_W+1)'(s1_valid_r)
                        + (QCNT_W+1)'(s2_valid_r);
  assign in_chan.ready = (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));
  assign in_fire       = in_chan.valid && in_chan.ready;

  nv21_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_fire),
    .pos       (cur_pos)
  );

  always_comb begin
    v_diff        = $signed({2'b00, in_chan.chroma_v}) - CHROMA_OFFSET;
    u_diff        = $signed({2'b00, in_chan.chroma_u}) - CHROMA_OFFSET;
    chroma_nxt.rv = SUM_W'(COEF_RV) * SUM_W'(v_diff);
    chroma_nxt.gu = SUM_W'(COEF_GU) * SUM_W'(u_diff);
    chroma_nxt.gv = SUM_W'(COEF_GV) * SUM_W'(v_diff);
    chroma_nxt.bu = SUM_W'(COEF_BU) * SUM_W'(u_diff);
    luma[0] = in_chan.luma_top_left;
    luma[1] = in_chan.luma_top_right;
    luma[2] = in_chan.luma_bottom_left;
    luma[3] = in_chan.luma_bottom_right;
  end

  always_ff @(posedge clk) begin
    chroma_r <= chroma_nxt;
    pos_s1_r <= cur_pos;
    pos_s2_r <= pos_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    nv21_lane u_lane (
      .clk    (clk),
      .luma   (luma[i]),
      .chroma (chroma_r),
      .rgba_r (pixels[i])
    );
  end

  nv21_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (s2_valid_r),
    .pos      (pos_s2_r),
    .pixels   (pixels),
    .rd_ready (out_chan.ready),
    .rd_valid (out_chan.valid),
    .rd_data  (result),
    .count    (queue_count)
  );

  assign out_chan.dest_row         = result.dest_row;
  assign out_chan.dest_col         = result.dest_col;
  assign out_chan.upper_left_rgba  = result.upper_left_rgba;
  assign out_chan.upper_right_rgba = result.upper_right_rgba;
  assign out_chan.lower_left_rgba  = result.lower_left_rgba;
  assign out_chan.lower_right_rgba = result.lower_right_rgba;
  assign out_chan.frame_done       = result.frame_done;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (QCNT_W+1)'(QUEUE_DEPTH))
    else $error("result queue overcommitted");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r ##1 s2_valid_r)
    else $error("accepted block lost in pipeline");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cur_pos.frame_done |=> cur_pos.dest_row == '0)
    else $error("block row did not wrap after frame end");

endmodule
